@@ hdl/bihr_pkg.sv @@
package bihr_pkg;

    localparam int VAL_W = 32;
    localparam int CFG_W = 4;

    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    localparam logic [1:0] CMD_LOAD_R = 2'd0;
    localparam logic [1:0] CMD_LOAD_A = 2'd1;
    localparam logic [1:0] CMD_LOAD_B = 2'd2;
    localparam logic [1:0] CMD_STEP   = 2'd3;

    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]              command;
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [VAL_W-1:0] value;
    } bihr_req_t;

    typedef struct packed {
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
        logic                    status;
        logic                    saturated;
    } bihr_rsp_t;

    typedef struct packed {
        logic clear;
        logic op_vld;
        logic round;
    } bihr_mac_ctl_t;

    typedef struct packed {
        logic                    busy;
        logic                    sat;
        logic signed [VAL_W-1:0] value;
    } bihr_mac_stat_t;

endpackage

@@ hdl/bilinear_impulse_response_step_unit.sv @@
// Load command: the result strobe comes in the cycle after start is taken; a new word may follow at once.
// Step command: busy through two passes over the n*n elements; elements are strobed in the
// second pass only, the last marked by last.
// The pace is set by the single multiply-accumulate unit that forms both products.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset clears all three matrices (per-entry valid bits) and sets the size to 8.
module bilinear_impulse_response_step_unit
    import bihr_pkg::*;
#(
    parameter int DIM_MAX   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bihr_req_t        req,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output logic             rsp_strobe,
    output bihr_rsp_t        rsp
);

    localparam int DEPTH = DIM_MAX * DIM_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int N_W   = $clog2(DIM_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SAT
    } state_t;

    state_t             state_reg, state_next;
    logic               stage_reg, stage_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [DIM_MAX-1:0] row_sat_reg, row_sat_next;
    logic               rd_vld_reg;
    logic [CFG_W-1:0]   size_reg;
    bihr_rsp_t          rsp_reg, rsp_next;
    logic               strobe_reg, strobe_next;

    logic [DEPTH-1:0]   r_valid_reg, a_valid_reg, b_valid_reg;
    logic               r_rv_reg, a_rv_reg, b_rv_reg;

    logic [N_W-1:0]     n;
    logic [IDX_W-1:0]   nm1;
    logic               in_range;
    logic               take_load;
    logic [AW-1:0]      ld_addr, ij_addr;

    logic               r_we, a_we, b_we, p_we;
    logic [AW-1:0]      r_waddr;
    logic [VAL_W-1:0]   r_wdata;
    logic [AW-1:0]      r_raddr, a_raddr, b_raddr, p_raddr;
    logic [VAL_W-1:0]   r_q, a_q, b_q, p_q;
    logic [VAL_W-1:0]   op_a, op_b;

    bihr_mac_ctl_t      mac_ctl;
    bihr_mac_stat_t     mac_stat;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        addr_of = AW'(r) * AW'(DIM_MAX) + AW'(c);
    endfunction

    // size register: zero acts as one, anything above DIM_MAX as DIM_MAX
    always_comb
    begin
        if (size_reg == '0)
        begin
            n = N_W'(1);
        end
        else if (size_reg > CFG_W'(DIM_MAX))
        begin
            n = N_W'(DIM_MAX);
        end
        else
        begin
            n = N_W'(size_reg);
        end
    end

    assign nm1      = IDX_W'(n - N_W'(1));
    assign in_range = (CFG_W'(req.row) < CFG_W'(n)) && (CFG_W'(req.col) < CFG_W'(n));
    assign busy     = (state_reg != S_IDLE);
    assign take_load = start && !busy && (req.command != CMD_STEP) && in_range;
    assign ld_addr  = AW'(req.row) * AW'(DIM_MAX) + AW'(req.col);
    assign ij_addr  = addr_of(i_reg, j_reg);

    always_comb
    begin
        r_we = 1'b0;
        a_we = 1'b0;
        b_we = 1'b0;
        unique case (req.command)
            CMD_LOAD_R: r_we = take_load;
            CMD_LOAD_A: a_we = take_load;
            CMD_LOAD_B: b_we = take_load;
            default:    r_we = 1'b0;
        endcase
        if (state_reg == S_SAT && stage_reg)
        begin
            r_we = 1'b1;
        end
    end

    assign r_waddr = busy ? ij_addr : ld_addr;
    assign r_wdata = busy ? mac_stat.value : req.value;
    assign p_we    = (state_reg == S_SAT) && !stage_reg;

    // first pass reads A row i and R column j, second pass P row i and B row j
    assign a_raddr = addr_of(i_reg, k_reg);
    assign r_raddr = addr_of(k_reg, j_reg);
    assign p_raddr = addr_of(i_reg, k_reg);
    assign b_raddr = addr_of(j_reg, k_reg);

    bihr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_r_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_q)
    );

    bihr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (ld_addr),
        .wdata (req.value),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    bihr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (ld_addr),
        .wdata (req.value),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    bihr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_p_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (ij_addr),
        .wdata (mac_stat.value),
        .raddr (p_raddr),
        .rdata (p_q)
    );

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= '0;
            a_valid_reg <= '0;
            b_valid_reg <= '0;
        end
        else
        begin
            if (r_we)
            begin
                r_valid_reg[r_waddr] <= 1'b1;
            end
            if (a_we)
            begin
                a_valid_reg[ld_addr] <= 1'b1;
            end
            if (b_we)
            begin
                b_valid_reg[ld_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_rv_reg <= r_valid_reg[r_raddr];
        a_rv_reg <= a_valid_reg[a_raddr];
        b_rv_reg <= b_valid_reg[b_raddr];
    end

    assign op_a = stage_reg ? p_q : (a_rv_reg ? a_q : '0);
    assign op_b = stage_reg ? (b_rv_reg ? b_q : '0) : (r_rv_reg ? r_q : '0);

    bihr_mac #(.DIM_MAX(DIM_MAX), .FRAC_BITS(FRAC_BITS)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  ($signed(op_a)),
        .op_b  ($signed(op_b)),
        .stat  (mac_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        row_sat_next   = row_sat_reg;
        rsp_next       = rsp_reg;
        strobe_next    = 1'b0;
        mac_ctl.clear  = 1'b0;
        mac_ctl.op_vld = rd_vld_reg;
        mac_ctl.round  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.command == CMD_STEP)
                    begin
                        state_next    = S_MAC;
                        stage_next    = 1'b0;
                        i_next        = '0;
                        j_next        = '0;
                        k_next        = '0;
                        row_sat_next  = '0;
                        mac_ctl.clear = 1'b1;
                    end
                    else
                    begin
                        strobe_next     = 1'b1;
                        rsp_next        = '0;
                        rsp_next.last   = 1'b1;
                        rsp_next.status = ~in_range;
                    end
                end
            end

            S_MAC:
            begin
                if (k_reg == nm1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                // wait for the last product to land in the accumulator
                if (!rd_vld_reg && !mac_stat.busy)
                begin
                    mac_ctl.round = 1'b1;
                    state_next    = S_SAT;
                end
            end

            S_SAT:
            begin
                k_next        = '0;
                state_next    = S_MAC;
                mac_ctl.clear = 1'b1;
                if (!stage_reg)
                begin
                    if (mac_stat.sat)
                    begin
                        row_sat_next[i_reg] = 1'b1;
                    end
                end
                else
                begin
                    strobe_next        = 1'b1;
                    rsp_next.out_row   = 3'(i_reg);
                    rsp_next.out_col   = 3'(j_reg);
                    rsp_next.out_value = mac_stat.value;
                    rsp_next.last      = (i_reg == nm1) && (j_reg == nm1);
                    rsp_next.status    = 1'b0;
                    rsp_next.saturated = mac_stat.sat | row_sat_reg[i_reg];
                end
                if (j_reg == nm1)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next = '0;
                        if (stage_reg)
                        begin
                            state_next    = S_IDLE;
                            mac_ctl.clear = 1'b0;
                        end
                        else
                        begin
                            stage_next = 1'b1;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stage_reg   <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            row_sat_reg <= '0;
            rd_vld_reg  <= 1'b0;
            size_reg    <= SIZE_RESET;
            rsp_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            row_sat_reg <= row_sat_next;
            rd_vld_reg  <= (state_reg == S_MAC);
            rsp_reg     <= rsp_next;
            strobe_reg  <= strobe_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    assign rsp_strobe = strobe_reg;
    assign rsp        = rsp_reg;

    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.command != CMD_STEP |=> strobe_reg && rsp_reg.last)
        else $error("load word not acknowledged in the next cycle");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> k_reg <= nm1)
        else $error("inner index beyond size in use");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SAT |-> !rd_vld_reg && !mac_stat.busy)
        else $error("result taken before accumulator drained");

    a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SAT && stage_reg && i_reg == nm1 && j_reg == nm1
        |=> state_reg == S_IDLE && strobe_reg && rsp_reg.last)
        else $error("step did not end with the last element");

endmodule

@@ hdl/bihr_ram.sv @@
module bihr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bihr_mac.sv @@
module bihr_mac
    import bihr_pkg::*;
#(
    parameter int DIM_MAX   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bihr_mac_ctl_t           ctl,
    input  logic signed [VAL_W-1:0] op_a,
    input  logic signed [VAL_W-1:0] op_b,
    output bihr_mac_stat_t          stat
);

    // room for DIM_MAX full-width products plus sign
    localparam int ACC_W = 2 * VAL_W + $clog2(DIM_MAX) + 1;
    localparam int RND_W = ACC_W + 1;
    localparam logic [RND_W-1:0] HALF = (RND_W'(1) << FRAC_BITS) >> 1;

    logic signed [2*VAL_W-1:0] prod_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [RND_W-1:0]   rnd_reg;
    logic signed [RND_W-1:0]   shifted;
    logic [RND_W-VAL_W:0]      upper;
    logic                      fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.op_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op_vld)
        begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctl.round)
        begin
            rnd_reg <= RND_W'(acc_reg) + $signed(HALF);
        end
    end

    // round half up was added above; drop the fraction and clamp to 32 bits
    assign shifted = rnd_reg >>> FRAC_BITS;
    assign upper   = shifted[RND_W-1:VAL_W-1];
    assign fits    = (&upper) | ~(|upper);

    assign stat.busy  = prod_vld_reg;
    assign stat.sat   = ~fits;
    assign stat.value = fits ? shifted[VAL_W-1:0]
                             : (shifted[RND_W-1] ? SAT_MIN : SAT_MAX);

endmodule

@@ test/tb_bilinear_impulse_response_step_unit.sv @@
module tb_bilinear_impulse_response_step_unit
    import bihr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 8;
    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int PHASE_WAIT = CYCLE_LIMIT;
    localparam int END_WAIT = 5000;
    localparam int PHASE_ITEMS = 14;
    localparam logic signed [79:0] ROUND_HALF = 80'sd32768;
    localparam logic signed [79:0] Q_MAX = 80'sd2147483647;
    localparam logic signed [79:0] Q_MIN = -80'sd2147483648;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    bihr_req_t        req = '0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             rsp_strobe;
    bihr_rsp_t        rsp;

    bilinear_impulse_response_step_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp)
    );

    always #10 clk = ~clk;

    // predictor state
    logic signed [31:0] shock_mat [64];
    logic signed [31:0] left_mat [64];
    logic signed [31:0] right_mat [64];
    logic [CFG_W-1:0]   size_reg = SIZE_RESET;

    bihr_req_t  pending [$];
    bihr_rsp_t  words_due [$];
    bihr_rsp_t  want;

    bit          idle_on = 1'b0;
    int          idle_left = 0;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;
    int unsigned items_sent = 0;
    int unsigned steps_taken = 0;
    int unsigned refused_loads = 0;
    int unsigned words_checked = 0;
    int unsigned sat_words = 0;
    int unsigned size_settings = 1;

    initial begin
        for (int i = 0; i < 64; i++) begin
            shock_mat[i] = '0;
            left_mat[i] = '0;
            right_mat[i] = '0;
        end
    end

    function automatic int eff_size(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM)
            return DIM;
        return int'(v);
    endfunction

    function automatic logic signed [31:0] round_saturate(input logic signed [79:0] acc,
                                                          output bit sat);
        logic signed [79:0] q;
        q = (acc + ROUND_HALF) >>> FRAC;
        sat = (q > Q_MAX) || (q < Q_MIN);
        if (q > Q_MAX)
            return SAT_MAX;
        if (q < Q_MIN)
            return SAT_MIN;
        return q[31:0];
    endfunction

    function automatic bihr_req_t make_req(input logic [1:0] c, input int r, input int k,
                                           input logic [31:0] v);
        bihr_req_t w;
        w.command = c;
        w.row = r[2:0];
        w.col = k[2:0];
        w.value = v;
        return w;
    endfunction

    function automatic logic [1:0] pick_load();
        case ($urandom_range(0, 2))
            0: return CMD_LOAD_R;
            1: return CMD_LOAD_A;
            default: return CMD_LOAD_B;
        endcase
    endfunction

    // Mix of moderate Q16.16 values, rounding-sized values, full-range words and corners.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 8)
            return 32'($urandom_range(0, 262144)) - 32'd131072;
        if (sel < 12)
            return 32'($urandom_range(0, 65535)) - 32'd32768;
        if (sel < 17)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Update the matrices for one accepted word and queue the words it must produce.
    task automatic compute_response(input bihr_req_t cmd_word);
        int n;
        int idx;
        bit s;
        bit row_sat [8];
        logic signed [79:0] acc;
        logic signed [31:0] prod_mat [64];
        bihr_rsp_t w;
        n = eff_size(size_reg);
        w = '0;
        if (cmd_word.command != CMD_STEP) begin
            w.last = 1'b1;
            if (cmd_word.row >= n || cmd_word.col >= n) begin
                w.status = 1'b1;
                refused_loads++;
            end else begin
                idx = cmd_word.row * 8 + cmd_word.col;
                case (cmd_word.command)
                    CMD_LOAD_R: shock_mat[idx] = cmd_word.value;
                    CMD_LOAD_A: left_mat[idx] = cmd_word.value;
                    default:    right_mat[idx] = cmd_word.value;
                endcase
            end
            words_due.push_back(w);
            return;
        end
        steps_taken++;
        for (int i = 0; i < n; i++) begin
            row_sat[i] = 1'b0;
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++)
                    acc = acc + longint'(left_mat[i*8+k]) * longint'(shock_mat[k*8+j]);
                prod_mat[i*8+j] = round_saturate(acc, s);
                if (s)
                    row_sat[i] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++)
                    acc = acc + longint'(prod_mat[i*8+k]) * longint'(right_mat[j*8+k]);
                w.out_value = round_saturate(acc, s);
                shock_mat[i*8+j] = w.out_value;
                w.out_row = 3'(i);
                w.out_col = 3'(j);
                w.last = (i == n - 1) && (j == n - 1);
                w.status = 1'b0;
                w.saturated = s || row_sat[i];
                words_due.push_back(w);
            end
        end
    endtask

    // Driver: present the head of the pending queue, with random idle bursts.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            req <= '0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                compute_response(req);
                void'(pending.pop_front());
                items_sent++;
            end
            if (idle_left > 0)
                idle_left--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                idle_left = $urandom_range(1, 18);
            if (idle_left == 0 && pending.size() != 0) begin
                start <= 1'b1;
                req <= pending[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed word must match the oldest expected word.
    always @(posedge clk) begin
        if (rst_n && rsp_strobe) begin
            words_checked++;
            if (rsp.saturated === 1'b1)
                sat_words++;
            if (words_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: row %0d col %0d value %h last %b status %b sat %b",
                             rsp.out_row, rsp.out_col, rsp.out_value, rsp.last, rsp.status,
                             rsp.saturated);
            end else begin
                want = words_due.pop_front();
                if (rsp.out_row !== want.out_row || rsp.out_col !== want.out_col ||
                    rsp.out_value !== want.out_value || rsp.last !== want.last ||
                    rsp.status !== want.status || rsp.saturated !== want.saturated) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch: expected row %0d col %0d value %h last %b st %b sat %b",
                                 want.out_row, want.out_col, want.out_value, want.last,
                                 want.status, want.saturated);
                        $display("          got      row %0d col %0d value %h last %b st %b sat %b",
                                 rsp.out_row, rsp.out_col, rsp.out_value, rsp.last,
                                 rsp.status, rsp.saturated);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold until the sender is empty, the block is idle and every word has come back, or the limit runs out.
    task automatic drain(input int limit);
        int waited;
        waited = 0;
        while ((pending.size() != 0 || start || busy || words_due.size() != 0)
               && waited < limit) begin
            @(negedge clk);
            waited++;
        end
        repeat (12) @(negedge clk);
    endtask

    initial begin
        int size_plan [11];
        int n;
        int loads;
        int made;
        size_plan = '{3, 0, 15, 1, 5, 2, 8, 7, 4, 6, 12};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero step, corner values, rounding halves, saturation in both stages
        idle_on = 1'b1;
        pending.push_back(make_req(CMD_STEP, 0, 0, 32'h0));
        pending.push_back(make_req(CMD_LOAD_R, 0, 0, SAT_MAX));
        pending.push_back(make_req(CMD_LOAD_R, 7, 7, SAT_MIN));
        pending.push_back(make_req(CMD_LOAD_R, 1, 1, 32'h0000_8000));
        pending.push_back(make_req(CMD_LOAD_R, 2, 2, 32'hFFFF_8000));
        pending.push_back(make_req(CMD_LOAD_A, 0, 0, SAT_MAX));
        pending.push_back(make_req(CMD_LOAD_A, 7, 7, SAT_MIN));
        pending.push_back(make_req(CMD_LOAD_A, 1, 1, 32'h0000_0001));
        pending.push_back(make_req(CMD_LOAD_A, 2, 2, 32'h0000_0001));
        pending.push_back(make_req(CMD_LOAD_B, 0, 0, SAT_MAX));
        pending.push_back(make_req(CMD_LOAD_B, 1, 1, 32'h0001_0000));
        pending.push_back(make_req(CMD_LOAD_B, 2, 2, 32'h0001_0000));
        pending.push_back(make_req(CMD_LOAD_B, 7, 7, SAT_MIN));
        pending.push_back(make_req(CMD_STEP, 7, 7, 32'hFFFF_FFFF));
        pending.push_back(make_req(CMD_LOAD_A, 3, 3, 32'h0001_0000));
        pending.push_back(make_req(CMD_LOAD_R, 3, 3, 32'h0001_8000));
        pending.push_back(make_req(CMD_LOAD_B, 3, 3, 32'hFFFF_0000));
        pending.push_back(make_req(CMD_LOAD_A, 4, 5, 32'h0002_0000));
        pending.push_back(make_req(CMD_LOAD_R, 5, 4, 32'hFFFF_FFFF));
        pending.push_back(make_req(CMD_LOAD_B, 4, 4, 32'h0000_8000));
        pending.push_back(make_req(CMD_STEP, 0, 0, 32'h0));
        pending.push_back(make_req(CMD_LOAD_A, 7, 7, 32'h0001_0000));
        pending.push_back(make_req(CMD_STEP, 0, 0, 32'h0));
        drain(PHASE_WAIT);

        for (int p = 0; p < 11; p++) begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= 4'(size_plan[p]);
            size_reg = 4'(size_plan[p]);
            @(posedge clk);
            cfg_we <= 1'b0;
            size_settings++;
            @(negedge clk);
            n = eff_size(size_reg);
            idle_on = (p < 9) && ($urandom_range(0, 3) != 0);
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    // loads of in-range elements, then one or two horizon steps
                    loads = $urandom_range(1, 6);
                    for (int l = 0; l < loads; l++)
                        pending.push_back(make_req(pick_load(), $urandom_range(0, n - 1),
                                                   $urandom_range(0, n - 1), pick_value()));
                    pending.push_back(make_req(CMD_STEP, $urandom_range(0, 7),
                                               $urandom_range(0, 7), $urandom));
                    made += loads + 1;
                    if ($urandom_range(0, 2) == 0) begin
                        pending.push_back(make_req(CMD_STEP, $urandom_range(0, 7),
                                                   $urandom_range(0, 7), $urandom));
                        made++;
                    end
                end else begin
                    // stray loads anywhere in the index space
                    pending.push_back(make_req(pick_load(), $urandom_range(0, 7),
                                               $urandom_range(0, 7), $urandom));
                    made++;
                end
            end
            drain(PHASE_WAIT);
        end

        drain(END_WAIT);
        if (words_due.size() != 0 || pending.size() != 0) begin
            failures += words_due.size() + pending.size();
            $display("%0d words never came back, %0d commands never taken",
                     words_due.size(), pending.size());
        end
        $display("Sent %0d commands over %0d size settings: %0d horizon steps, %0d refused loads.",
                 items_sent, size_settings, steps_taken, refused_loads);
        $display("Checked %0d result words, %0d of them flagged saturated; %0d failures.",
                 words_checked, sat_words, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
